// ----- src/tsg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants of the tone sample generator
// Field widths, register indexes, PCM levels and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int SAMPLE_RATE_HZ_DEF = 22050;

    localparam int PHASE_W = 17;
    localparam int COUNT_W = 16;
    localparam int FREQ_W  = 15;
    localparam int PCM_W   = 8;
    localparam int MAG_W   = 7;
    localparam int MAG_MAX = 127;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR  = 2'd2;

    localparam logic            MODE_RESET = 1'b0;
    localparam logic [FREQ_W-1:0]  FREQ_RESET = 15'd440;
    localparam logic [COUNT_W-1:0] DUR_RESET  = 16'd2205;

    localparam logic [PCM_W-1:0] PCM_HIGH = 8'hFF;
    localparam logic [PCM_W-1:0] PCM_LOW  = 8'h00;
    localparam logic [PCM_W-1:0] PCM_MID  = 8'h80;

    localparam real PI = 3.14159265358979323846;

    typedef struct packed {
        logic                mode;   // 1 = sine
        logic [FREQ_W-1:0]   freq;
        logic [COUNT_W-1:0]  dur;
    } cfg_t;

    typedef struct packed {
        logic restart;
        logic div_step;
        logic fold_init;
        logic fold_hi;
        logic fold_lo;
        logic mirror;
        logic search_step;
        logic fm_step;
        logic sq_commit;
        logic sine_commit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic search_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ----- src/tsg_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_cfg_regs: configuration register file
// Decodes writes on the config channel into mode, frequency and duration.
// ----------------------------------------------------------------------------
module tsg_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tsg_pkg::cfg_t                           cfg
);

    logic                            mode_reg;
    logic [tsg_pkg::FREQ_W-1:0]      freq_reg;
    logic [tsg_pkg::COUNT_W-1:0]     dur_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tsg_pkg::MODE_RESET;
            freq_reg <= tsg_pkg::FREQ_RESET;
            dur_reg  <= tsg_pkg::DUR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tsg_pkg::CFG_MODE: mode_reg <= cfg_data[0];
                tsg_pkg::CFG_FREQ: freq_reg <= cfg_data[tsg_pkg::FREQ_W-1:0];
                tsg_pkg::CFG_DUR:  dur_reg  <= cfg_data[tsg_pkg::COUNT_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg.mode = mode_reg;
    assign cfg.freq = freq_reg;
    assign cfg.dur  = dur_reg;

endmodule
`default_nettype wire

// ----- src/tsg_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_ctrl: sequencing state machine
// Accepts a tick word, runs the period divider on restart, then walks the
// square or sine path and commits the sample once the output register frees.
// ----------------------------------------------------------------------------
module tsg_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           restart_in,
    input  wire logic           sine_mode,
    input  tsg_pkg::stat_t      stat,
    output tsg_pkg::cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DIV      = 9'b000000010,
        ST_SQUARE   = 9'b000000100,
        ST_FOLD0    = 9'b000001000,
        ST_FOLD1    = 9'b000010000,
        ST_FOLD2    = 9'b000100000,
        ST_MIRROR   = 9'b001000000,
        ST_SEARCH   = 9'b010000000,
        ST_SINE_OUT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.restart = restart_in;
                    if (restart_in) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = sine_mode ? ST_FOLD0 : ST_SQUARE;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = sine_mode ? ST_FOLD0 : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (stat.out_free) begin
                    cmd.sq_commit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FOLD0: begin
                cmd.fold_init = 1'b1;
                state_next    = ST_FOLD1;
            end
            ST_FOLD1: begin
                cmd.fold_hi = 1'b1;
                cmd.fm_step = 1'b1;
                state_next  = ST_FOLD2;
            end
            ST_FOLD2: begin
                cmd.fold_lo = 1'b1;
                cmd.fm_step = 1'b1;
                state_next  = ST_MIRROR;
            end
            ST_MIRROR: begin
                cmd.mirror  = 1'b1;
                cmd.fm_step = 1'b1;
                state_next  = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                cmd.fm_step     = 1'b1;
                if (stat.search_last) begin
                    state_next = ST_SINE_OUT;
                end
            end
            ST_SINE_OUT: begin
                if (stat.out_free) begin
                    cmd.sine_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/tsg_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_datapath: tone state, period divider, sine fold and table search
// Restoring divider gives rate/freq one quotient bit a cycle. The sine
// magnitude is a binary search over the 127 phase thresholds at which
// floor(127*sin) steps up; the thresholds are built at elaboration.
// ----------------------------------------------------------------------------
module tsg_datapath #(
    parameter int SAMPLE_RATE_HZ = tsg_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  tsg_pkg::cmd_t                   cmd,
    input  tsg_pkg::cfg_t                   cfg,
    input  wire logic                       m_tready,
    output tsg_pkg::stat_t                  stat,
    output logic                            m_tvalid,
    output logic [tsg_pkg::PCM_W-1:0]       m_pcm,
    output logic                            m_last
);

    localparam int PW     = tsg_pkg::PHASE_W;
    localparam int WW     = PW + 2;
    localparam int FW     = tsg_pkg::FREQ_W;
    localparam int CW     = tsg_pkg::COUNT_W;
    localparam int MW     = tsg_pkg::MAG_W;
    localparam int DIV_IW = $clog2(PW);
    localparam int SB_W   = $clog2(MW);

    localparam logic [PW-1:0] RateV  = PW'(SAMPLE_RATE_HZ);
    localparam logic [WW-1:0] Rate1W = WW'(SAMPLE_RATE_HZ);
    localparam logic [WW-1:0] Rate2W = WW'(2 * SAMPLE_RATE_HZ);

    // thr_tab[m]: smallest quarter-phase r with floor(127*sin) >= m
    logic [PW-1:0] thr_tab [0:tsg_pkg::MAG_MAX];

    for (genvar g = 0; g <= tsg_pkg::MAG_MAX; g++) begin : g_thr
        localparam real Frac = real'(g) / real'(tsg_pkg::MAG_MAX);
        localparam int  Thr  = (g == 0) ? 0 :
                               (g == tsg_pkg::MAG_MAX) ? SAMPLE_RATE_HZ :
                               int'($ceil(real'(SAMPLE_RATE_HZ) * $asin(Frac) * 2.0
                                          / tsg_pkg::PI));
        assign thr_tab[g] = PW'(Thr);
    end

    // tone state
    logic [CW-1:0]      count_reg;
    logic [PW-1:0]      phase_reg;
    logic [PW-1:0]      period_reg;

    // divider
    logic [FW-1:0]      rem_reg;
    logic [PW-1:0]      quot_reg;
    logic [DIV_IW-1:0]  didx_reg;

    // sine working registers
    logic [WW-1:0]      w_reg;
    logic [PW-1:0]      pr_reg;
    logic [FW-1:0]      fm_reg;
    logic               qh_reg;
    logic               ql_reg;
    logic [PW-1:0]      r_reg;
    logic [MW-1:0]      mag_reg;
    logic [SB_W-1:0]    sb_reg;

    // output word
    logic                          m_tvalid_reg;
    logic [tsg_pkg::PCM_W-1:0]     m_pcm_reg;
    logic                          m_last_reg;

    // divider step
    logic [FW:0]        div_shift;
    logic               div_ge;
    logic [FW:0]        div_sub;
    logic [PW-1:0]      quot_next;

    assign div_shift = {rem_reg, RateV[didx_reg]};
    assign div_ge    = (div_shift >= {1'b0, cfg.freq});
    assign div_sub   = div_shift - {1'b0, cfg.freq};
    assign quot_next = {quot_reg[PW-2:0], div_ge};

    // sine helpers
    logic [PW-1:0]      pr_calc;
    logic [MW-1:0]      cand;
    logic [PW:0]        sine_sum;
    logic [PW-1:0]      sine_phase;
    logic [tsg_pkg::PCM_W-1:0] sine_pcm;

    assign pr_calc   = (phase_reg >= RateV) ? (phase_reg - RateV) : phase_reg;
    assign cand      = mag_reg | (MW'(1) << sb_reg);
    assign sine_sum  = {1'b0, pr_reg} + {{(PW + 1 - FW){1'b0}}, fm_reg};
    assign sine_phase = (sine_sum >= {1'b0, RateV}) ? PW'(sine_sum - {1'b0, RateV})
                                                    : sine_sum[PW-1:0];
    assign sine_pcm  = qh_reg ? (tsg_pkg::PCM_MID - {1'b0, mag_reg})
                              : (tsg_pkg::PCM_MID + {1'b0, mag_reg});

    // square helpers
    logic [PW:0]        ph_inc;
    logic [PW-1:0]      sq_phase;
    logic [tsg_pkg::PCM_W-1:0] sq_pcm;

    assign ph_inc   = {1'b0, phase_reg} + {{PW{1'b0}}, 1'b1};
    assign sq_phase = (ph_inc >= {1'b0, period_reg}) ? '0 : ph_inc[PW-1:0];
    assign sq_pcm   = (phase_reg < (period_reg >> 1)) ? tsg_pkg::PCM_HIGH
                                                      : tsg_pkg::PCM_LOW;

    logic commit;
    logic last_now;

    assign commit   = cmd.sq_commit | cmd.sine_commit;
    assign last_now = (count_reg == (cfg.dur - CW'(1)));

    // tone state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            phase_reg    <= '0;
            period_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.restart) begin
                count_reg <= '0;
                phase_reg <= '0;
            end else if (commit) begin
                count_reg <= count_reg + CW'(1);
                phase_reg <= cmd.sine_commit ? sine_phase : sq_phase;
            end
            if (cmd.div_step && stat.div_last) begin
                period_reg <= (cfg.freq == '0) ? '0 : quot_next;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.restart) begin
            rem_reg  <= '0;
            didx_reg <= DIV_IW'(PW - 1);
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_sub[FW-1:0] : div_shift[FW-1:0];
            quot_reg <= quot_next;
            didx_reg <= didx_reg - DIV_IW'(1);
        end

        if (cmd.fold_init) begin
            pr_reg <= pr_calc;
            w_reg  <= {pr_calc, 2'b00};
            fm_reg <= cfg.freq;
        end else if (cmd.fm_step && ({{(PW - FW){1'b0}}, fm_reg} >= RateV)) begin
            fm_reg <= FW'({{(PW - FW){1'b0}}, fm_reg} - RateV);
        end

        // quadrant = phase*4 / rate, two compare-subtract steps
        if (cmd.fold_hi) begin
            qh_reg <= (w_reg >= Rate2W);
            if (w_reg >= Rate2W) begin
                w_reg <= w_reg - Rate2W;
            end
        end
        if (cmd.fold_lo) begin
            ql_reg <= (w_reg >= Rate1W);
            if (w_reg >= Rate1W) begin
                w_reg <= w_reg - Rate1W;
            end
        end

        if (cmd.mirror) begin
            r_reg   <= ql_reg ? (RateV - w_reg[PW-1:0]) : w_reg[PW-1:0];
            mag_reg <= '0;
            sb_reg  <= SB_W'(MW - 1);
        end else if (cmd.search_step) begin
            if (thr_tab[cand] <= r_reg) begin
                mag_reg <= cand;
            end
            sb_reg <= sb_reg - SB_W'(1);
        end

        if (commit) begin
            m_pcm_reg  <= cmd.sine_commit ? sine_pcm : sq_pcm;
            m_last_reg <= last_now;
        end
    end

    assign stat.div_last    = (didx_reg == '0);
    assign stat.search_last = (sb_reg == '0);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_pcm    = m_pcm_reg;
    assign m_last   = m_last_reg;

endmodule
`default_nettype wire

// ----- src/tone_sample_generator.sv -----
`default_nettype none
// Square sample: committed to the output word once the output register is free; sine
//   sample: the quadrant fold and the 7-step threshold search run first. A restart
//   first runs the bit-serial rate/freq divider. Only one tick word is in flight.
// Output register lets the next word be taken while a sample waits on m_tready.
// Reset (aresetn low, synchronous): counters, phase and period clear, config to defaults.
// ----------------------------------------------------------------------------
// tone_sample_generator: square and sine 8-bit PCM tone generator
// One sample per tick word; restart bit starts a new tone at sample zero.
// ----------------------------------------------------------------------------
module tone_sample_generator #(
    parameter int SAMPLE_RATE_HZ = tsg_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input tick
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [0] restart
    // output sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // [7:0] pcm_sample
    output logic                                    m_tlast,   // last_sample
    // config writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tsg_pkg::cfg_t  cfg;
    tsg_pkg::cmd_t  cmd;
    tsg_pkg::stat_t stat;

    tsg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .restart_in (s_tdata[0]),
        .sine_mode  (cfg.mode),
        .stat       (stat),
        .cmd        (cmd)
    );

    tsg_datapath #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_pcm    (m_tdata),
        .m_last   (m_tlast)
    );

    // one word in flight: accepting drops ready in the cycle after
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("tick accepted while busy");

    // returning to idle means a sample was just committed
    a_idle_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> m_tvalid)
        else $error("item finished without a sample");

    // a new sample only appears from a busy controller
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("sample without work");

    // commit only when the output register can take it
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sq_commit || cmd.sine_commit) |-> stat.out_free)
        else $error("sample overwrote a pending word");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tone sample generator
// Drives tick words with random restarts and random config phases, predicts
// every PCM sample and last flag in square and sine mode, and checks each
// output word in order against the prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] pcm;
    logic       last;
} tone_word_t;

class pcm_scoreboard;
    localparam int unsigned RATE = tsg_pkg::SAMPLE_RATE_HZ_DEF;
    localparam longint unsigned HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    bit        mode;
    bit [14:0] freq;
    bit [15:0] dur;
    bit [15:0] count;
    bit [16:0] phase;
    bit [16:0] period;
    tone_word_t samples_due[$];
    int unsigned errors;
    int unsigned checked;

    function new();
        mode    = tsg_pkg::MODE_RESET;
        freq    = tsg_pkg::FREQ_RESET;
        dur     = tsg_pkg::DUR_RESET;
        count   = '0;
        phase   = '0;
        period  = '0;
        errors  = 0;
        checked = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
        case (idx)
            tsg_pkg::CFG_MODE: mode = data[0];
            tsg_pkg::CFG_FREQ: freq = data[14:0];
            tsg_pkg::CFG_DUR:  dur  = data;
            default: ;
        endcase
    endfunction

    // (a*b) >> 62, Q2.62
    function longint unsigned mul_q62(longint unsigned a, longint unsigned b);
        bit [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // floor(127*sin(r/RATE * pi/2)) by a Taylor sum in Q2.62
    function longint unsigned quarter_mag(longint unsigned r);
        longint unsigned x, x2, term, sum, frac, whole;
        if (r == 0) return 0;
        if (r >= RATE) return 127;
        x = (HALF_PI_Q62 / RATE) * r + ((HALF_PI_Q62 % RATE) * r) / RATE;
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (longint unsigned n = 1; n <= 12; n++) begin
            term = mul_q62(term, x2) / ((2 * n) * (2 * n + 1));
            if (n[0]) sum -= term;
            else sum += term;
        end
        whole = sum >> 62;
        frac = sum & 64'h3FFF_FFFF_FFFF_FFFF;
        whole = whole * 127 + (((frac >> 31) * 127
                + (((frac & 64'h7FFF_FFFF) * 127) >> 31)) >> 31);
        return (whole > 127) ? 127 : whole;
    endfunction

    function bit [7:0] sine_level(bit [16:0] pos);
        int unsigned u, quad, rem;
        bit [7:0] mag;
        u = (int'(pos) % RATE) * 4;
        quad = u / RATE;
        rem = u % RATE;
        mag = 8'(quarter_mag(quad[0] ? RATE - rem : rem));
        return (quad >= 2) ? tsg_pkg::PCM_MID - mag : tsg_pkg::PCM_MID + mag;
    endfunction

    function void predict_sample(bit restart);
        tone_word_t w;
        int unsigned nxt;
        if (restart) begin
            count = '0;
            phase = '0;
            period = (freq == 0) ? '0 : 17'(RATE / freq);
        end
        if (mode) begin
            w.pcm = sine_level(phase);
            phase = 17'(((phase % RATE) + (freq % RATE)) % RATE);
        end else begin
            w.pcm = (phase < period / 2) ? tsg_pkg::PCM_HIGH : tsg_pkg::PCM_LOW;
            nxt = int'(phase) + 1;
            phase = (nxt >= period) ? '0 : 17'(nxt);
        end
        w.last = (count == 16'(dur - 16'd1));
        count = count + 16'd1;
        samples_due.push_back(w);
    endfunction

    function void check_sample(logic [7:0] pcm, logic last);
        tone_word_t w;
        checked++;
        if (samples_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("word %0d: unexpected output pcm %02h last %0b", checked, pcm, last);
            return;
        end
        w = samples_due.pop_front();
        if (pcm !== w.pcm || last !== w.last) begin
            errors++;
            if (errors <= 10)
                $display("word %0d: expected pcm %02h last %0b, got pcm %02h last %0b",
                         checked, w.pcm, w.last, pcm, last);
        end
    endfunction

    function int pending();
        return samples_due.size();
    endfunction
endclass

module testbench;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_TICKS = 1160;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] pcm_sample
    logic        m_tlast;          // last_sample
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [tsg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tsg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bit          calm = 1'b0;      // no random idling on either side
    int unsigned hold_asked = 0;
    int unsigned hold_done = 0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;

    pcm_scoreboard sb;

    tone_sample_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_sample(m_tdata, m_tlast);
    end

    task automatic send_tick(input bit restart);
        while (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_sample(restart);
    endtask

    task automatic tone_burst(input bit opens, input int length, input int restart_pct);
        for (int i = 0; i < length; i++)
            send_tick((i == 0) ? opens : ($urandom_range(99) < restart_pct));
    endtask

    // stop sending and wait until every predicted word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(idx, data);
    endtask

    // unused data bits carry noise; the block must ignore them
    task automatic configure(input bit mode, input bit [14:0] freq, input bit [15:0] dur);
        write_reg(tsg_pkg::CFG_MODE, {15'($urandom), mode});
        write_reg(tsg_pkg::CFG_FREQ, {1'($urandom), freq});
        write_reg(tsg_pkg::CFG_DUR, dur);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        int phase_no;
        bit mode;
        bit [14:0] freq;
        bit [15:0] dur;

        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults; no restart yet, so the square period is still zero
        tone_burst(1'b0, 2, 0);
        tone_burst(1'b1, 2, 0);
        drain();
        configure(1'b0, 15'd1, 16'd1);        // longest period, last on the first word only
        tone_burst(1'b1, 3, 0);
        drain();
        configure(1'b0, 15'd22050, 16'd65535); // period of one
        tone_burst(1'b1, 2, 0);
        drain();
        configure(1'b0, 15'd0, 16'd2205);     // zero frequency
        tone_burst(1'b1, 2, 0);
        drain();
        configure(1'b0, 15'd32767, 16'd2);    // above the sample rate
        tone_burst(1'b1, 2, 0);
        drain();
        configure(1'b1, 15'd3000, 16'd0);     // sine from phase zero, zero duration
        tone_burst(1'b1, 4, 0);
        drain();
        configure(1'b0, 15'd3000, 16'd0);     // switch to square mid-tone
        tone_burst(1'b0, 2, 0);
        drain();
        configure(1'b1, 15'd32767, 16'd0);    // back to sine, step wraps mod rate
        tone_burst(1'b0, 2, 0);
        drain();
        configure(1'b1, 15'd22050, 16'd4);
        tone_burst(1'b1, 2, 0);

        // long tone under a receiver hold-off: the block fills and stalls its input
        drain();
        configure(1'b0, 15'($urandom_range(1, 22050)), 16'd40);
        calm <= 1'b1;
        hold_asked <= hold_asked + 1;
        tone_burst(1'b1, 40, 0);
        calm <= 1'b0;
        tone_burst(1'b0, 20, 0);

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_TICKS) begin
            drain();
            mode = 1'($urandom);
            case ($urandom_range(9))
                0: freq = 15'd0;
                1: freq = 15'd32767;
                2: freq = 15'd22050;
                3: freq = 15'($urandom_range(1, 100));
                4: freq = 15'($urandom_range(22051, 32767));
                default: freq = 15'($urandom_range(1, 22050));
            endcase
            case ($urandom_range(9))
                0: dur = 16'd0;
                1: dur = 16'd65535;
                2: dur = 16'($urandom);
                default: dur = 16'($urandom_range(1, 48));
            endcase
            configure(mode, freq, dur);
            if (dur >= 1 && dur <= 48) len = dur + $urandom_range(0, 8);
            else len = $urandom_range(10, 40);
            calm <= (phase_no >= 8 && phase_no < 14);
            tone_burst($urandom_range(99) < 85, len, 2);
            sent += len;
            phase_no++;
        end

        drain();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/tsg_pkg.sv
src/tsg_cfg_regs.sv
src/tsg_ctrl.sv
src/tsg_datapath.sv
src/tone_sample_generator.sv
bench/testbench.sv
